@@ hw/rtl/mbre_pkg.sv @@
// Shared types and constants for the mono bitmap raster engine.
`default_nettype none

package mbre_pkg;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_RECT  = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_SET = 2'd0,
    MODE_CLR = 2'd1,
    MODE_INV = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned X_W      = 7;
  localparam int unsigned Y_W      = 6;
  localparam int unsigned WPX_W    = 8;
  localparam int unsigned HPX_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned RD_W     = 8;

  localparam logic [WPX_W-1:0] WIDTH_RST  = 8'd128;
  localparam logic [HPX_W-1:0] HEIGHT_RST = 7'd64;

  // word index within a row, bit offset within a word, row base address
  localparam int unsigned WI_W   = 6;
  localparam int unsigned OFF_W  = 6;
  localparam int unsigned BASE_W = 11;
  localparam int unsigned ROWS_W = 7;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic              rd;
    logic              draw;
    logic              err;
    mode_e             mode;
    logic [WI_W-1:0]   wi0;
    logic [WI_W-1:0]   wi1;
    logic [WI_W-1:0]   stride;
    logic [OFF_W-1:0]  lo;
    logic [OFF_W-1:0]  hi;
    logic [BASE_W-1:0] base;
    logic [ROWS_W-1:0] rows;
  } cmd_t;

  typedef struct packed {
    logic [RD_W-1:0] read_word;
    logic            range_error;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mono_bitmap_raster_engine.sv @@
// Top level of the mono bitmap raster engine: front, command queue, back, result queue.
// The front captures an item, reckons word indices in F_DIV, pushes the command in F_PUSH;
// the back pops it, walks its words in B_RUN and writes drawn words back from s2 registers.
// The front takes no new item until its command is pushed. Each word of a draw item uses
// the single write port (up to MAX_ROW_WORDS * MAX_ROWS words for a fill). After reset a
// clearing pass zeroes the frame store, one word per cycle; full stays high until it ends.
`default_nettype none

module mono_bitmap_raster_engine #(
  parameter int unsigned WORD_BITS     = 8,
  parameter int unsigned MAX_ROW_WORDS = 16,
  parameter int unsigned MAX_ROWS      = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mbre_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mbre_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [mbre_pkg::OP_W-1:0]        op_i,
  input  wire logic [mbre_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [mbre_pkg::X_W-1:0]         x_i,
  input  wire logic [mbre_pkg::Y_W-1:0]         y_i,
  input  wire logic [mbre_pkg::WPX_W-1:0]       w_i,
  input  wire logic [mbre_pkg::HPX_W-1:0]       h_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [mbre_pkg::RD_W-1:0]             read_word_o,
  output logic                                  range_error_o
);

  import mbre_pkg::*;

  cmd_t                 cmd_in, cmd_out;
  logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_rd;
  res_t                 res_in, res_out;
  logic                 res_push, res_full;
  logic [RES_CNT_W-1:0] res_cnt;
  logic [$bits(res_t)-1:0] res_rd;
  logic                 clearing;

  assign cmd_out       = cmd_t'(cmd_rd);
  assign res_out       = res_t'(res_rd);
  assign read_word_o   = res_out.read_word;
  assign range_error_o = res_out.range_error;

  mbre_front #(
    .WORD_BITS     (WORD_BITS),
    .MAX_ROW_WORDS (MAX_ROW_WORDS),
    .MAX_ROWS      (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_o     (full),
    .op_i       (op_i),
    .mode_i     (mode_i),
    .x_i        (x_i),
    .y_i        (y_i),
    .w_i        (w_i),
    .h_i        (h_i),
    .hold_i     (clearing),
    .cmd_o      (cmd_in),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full)
  );

  mbre_fifo #(
    .DW    ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rd),
    .empty_o (cmd_empty),
    .count_o ()
  );

  mbre_back #(
    .WORD_BITS     (WORD_BITS),
    .MAX_ROW_WORDS (MAX_ROW_WORDS),
    .MAX_ROWS      (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_cnt_i   (res_cnt),
    .clearing_o  (clearing)
  );

  mbre_fifo #(
    .DW    ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rd),
    .empty_o (empty),
    .count_o (res_cnt)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mbre_fifo.sv @@
// Small synchronous FIFO used for the command and result queues.
`default_nettype none

module mbre_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [DW-1:0]                data_i,
  output logic                              full_o,
  input  wire logic                         pop_i,
  output logic [DW-1:0]                     data_o,
  output logic                              empty_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mbre_front.sv @@
// Front end: config registers, item capture, range check and command decode.
`default_nettype none

module mbre_front #(
  parameter int unsigned WORD_BITS     = 8,
  parameter int unsigned MAX_ROW_WORDS = 16,
  parameter int unsigned MAX_ROWS      = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [mbre_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mbre_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                 push_i,
  output logic                                      full_o,
  input  wire logic [mbre_pkg::OP_W-1:0]            op_i,
  input  wire logic [mbre_pkg::MODE_W-1:0]          mode_i,
  input  wire logic [mbre_pkg::X_W-1:0]             x_i,
  input  wire logic [mbre_pkg::Y_W-1:0]             y_i,
  input  wire logic [mbre_pkg::WPX_W-1:0]           w_i,
  input  wire logic [mbre_pkg::HPX_W-1:0]           h_i,
  input  wire logic                                 hold_i,
  output mbre_pkg::cmd_t                            cmd_o,
  output logic                                      cmd_push_o,
  input  wire logic                                 cmd_full_i
);

  import mbre_pkg::*;

  localparam int unsigned W_LIM = MAX_ROW_WORDS * WORD_BITS;
  localparam int unsigned SHIFT = 16;
  localparam int unsigned RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_e;

  fstate_e            state_q;
  logic [WPX_W-1:0]   width_q;
  logic [HPX_W-1:0]   height_q;

  op_e                op_q;
  logic [MODE_W-1:0]  mode_q;
  logic [X_W-1:0]     x_q;
  logic [Y_W-1:0]     y_q;
  logic [WPX_W-1:0]   w_q, wu_q;
  logic [HPX_W-1:0]   h_q, hu_q;

  logic [WI_W-1:0]    qx_q, qx_d, ql_q, ql_d, s_q, s_d;
  logic [8:0]         last_q, last_d;
  logic               err_q, err_d;

  logic [WPX_W-1:0]   wu;
  logic [HPX_W-1:0]   hu;
  logic [31:0]        prod_x, prod_l, prod_s;
  logic               pix_ok, rect_ok, mode_ok, accept;
  logic [OFF_W-1:0]   rem_x, rem_l;
  logic [BASE_W-1:0]  ybase;

  assign wu = (int'(width_q) > W_LIM) ? WPX_W'(W_LIM) : width_q;
  assign hu = (int'(height_q) > MAX_ROWS) ? HPX_W'(MAX_ROWS) : height_q;

  assign full_o     = (state_q != F_IDLE) || hold_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = (state_q == F_PUSH) && !cmd_full_i;

  // quotients by WORD_BITS through a scaled reciprocal, exact below 1024
  always_comb begin
    last_d  = 9'(x_q) + 9'(w_q) - 9'd1;
    prod_x  = 32'(x_q) * 32'(RECIP);
    prod_l  = 32'(last_d) * 32'(RECIP);
    prod_s  = (32'(wu_q) + 32'(WORD_BITS - 1)) * 32'(RECIP);
    qx_d    = WI_W'(prod_x >> SHIFT);
    ql_d    = WI_W'(prod_l >> SHIFT);
    s_d     = WI_W'(prod_s >> SHIFT);
    pix_ok  = (8'(x_q) < wu_q) && (7'(y_q) < hu_q);
    rect_ok = pix_ok && ((9'(x_q) + 9'(w_q)) <= 9'(wu_q)) &&
              ((8'(y_q) + 8'(h_q)) <= 8'(hu_q));
    case (op_q)
      OP_PIXEL: err_d = !pix_ok;
      OP_RECT:  err_d = !rect_ok;
      OP_FILL:  err_d = 1'b0;
      OP_READ:  err_d = !pix_ok;
      default:  err_d = 1'b0;
    endcase
  end

  always_comb begin
    rem_x   = OFF_W'(int'(x_q) - int'(qx_q) * WORD_BITS);
    rem_l   = OFF_W'(int'(last_q) - int'(ql_q) * WORD_BITS);
    ybase   = BASE_W'(y_q) * BASE_W'(s_q);
    mode_ok = mode_q inside {MODE_SET, MODE_CLR, MODE_INV};

    cmd_o        = '0;
    cmd_o.err    = err_q;
    cmd_o.mode   = mode_e'(mode_q);
    cmd_o.stride = s_q;
    cmd_o.wi0    = qx_q;
    cmd_o.wi1    = qx_q;
    cmd_o.lo     = rem_x;
    cmd_o.hi     = rem_x;
    cmd_o.base   = ybase;
    cmd_o.rows   = ROWS_W'(1);
    case (op_q)
      OP_PIXEL: begin
        cmd_o.draw = !err_q && mode_ok;
      end
      OP_RECT: begin
        cmd_o.wi1  = ql_q;
        cmd_o.hi   = rem_l;
        cmd_o.rows = ROWS_W'(h_q);
        cmd_o.draw = !err_q && (w_q != '0) && (h_q != '0) && mode_ok;
      end
      OP_FILL: begin
        cmd_o.wi0  = '0;
        cmd_o.wi1  = s_q - 1'b1;
        cmd_o.lo   = '0;
        cmd_o.hi   = OFF_W'(WORD_BITS - 1);
        cmd_o.base = '0;
        cmd_o.rows = ROWS_W'(hu_q);
        cmd_o.draw = (s_q != '0) && (hu_q != '0) && mode_ok;
      end
      OP_READ: begin
        cmd_o.rd = !err_q;
      end
      default: begin
        cmd_o.draw = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= HPX_W'(cfg_data_i);
          default:    width_q  <= width_q;
        endcase
      end
      case (state_q)
        F_IDLE:  if (accept) state_q <= F_DIV;
        F_DIV:   state_q <= F_PUSH;
        F_PUSH:  if (!cmd_full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      mode_q <= mode_i;
      x_q    <= x_i;
      y_q    <= y_i;
      w_q    <= w_i;
      h_q    <= h_i;
      wu_q   <= wu;
      hu_q   <= hu;
    end
    if (state_q == F_DIV) begin
      qx_q   <= qx_d;
      ql_q   <= ql_d;
      s_q    <= s_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mbre_back.sv @@
// Back end: frame store with clearing pass, word walker with read-modify-write, result issue.
`default_nettype none

module mbre_back #(
  parameter int unsigned WORD_BITS     = 8,
  parameter int unsigned MAX_ROW_WORDS = 16,
  parameter int unsigned MAX_ROWS      = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mbre_pkg::cmd_t                  cmd_i,
  input  wire logic                            cmd_empty_i,
  output logic                                 cmd_pop_o,
  output mbre_pkg::res_t                       res_o,
  output logic                                 res_push_o,
  input  wire logic                            res_full_i,
  input  wire logic [mbre_pkg::RES_CNT_W-1:0]  res_cnt_i,
  output logic                                 clearing_o
);

  import mbre_pkg::*;

  localparam int unsigned DEPTH = MAX_ROW_WORDS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [WORD_BITS-1:0] ALL = {WORD_BITS{1'b1}};

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_RUN} bstate_e;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q, wdata_q;

  bstate_e              state_q;
  logic [AW-1:0]        clr_q;
  cmd_t                 cmd_q;
  logic [BASE_W-1:0]    row_base_q;
  logic [ROWS_W-1:0]    rows_left_q;
  logic [WI_W-1:0]      wi_q;

  logic                 s2_valid_q, s2_write_q, s2_last_q, s2_read_q, s2_err_q;
  logic [AW-1:0]        s2_addr_q;
  logic [WORD_BITS-1:0] s2_mask_q;
  mode_e                s2_mode_q;
  logic                 fwd_q;

  logic [AW-1:0]        issue_addr;
  logic                 issue, issue_write, issue_last, first_w, last_w, hit, room;
  logic [OFF_W-1:0]     lo_e, hi_e;
  logic [WORD_BITS-1:0] mask, cur_word, new_word;

  always_comb begin
    issue       = (state_q == B_RUN);
    issue_write = issue && cmd_q.draw;
    issue_addr  = AW'(row_base_q + BASE_W'(wi_q));
    first_w     = (wi_q == cmd_q.wi0);
    last_w      = (wi_q == cmd_q.wi1);
    lo_e        = first_w ? cmd_q.lo : '0;
    hi_e        = last_w ? cmd_q.hi : OFF_W'(WORD_BITS - 1);
    mask        = (ALL >> lo_e) & (ALL << (OFF_W'(WORD_BITS - 1) - hi_e));
    issue_last  = !cmd_q.draw || (last_w && (rows_left_q == ROWS_W'(1)));
    hit         = issue && s2_valid_q && s2_write_q && (issue_addr == s2_addr_q);

    cur_word = fwd_q ? wdata_q : rdata_q;
    case (s2_mode_q)
      MODE_SET: new_word = cur_word | s2_mask_q;
      MODE_CLR: new_word = cur_word & ~s2_mask_q;
      MODE_INV: new_word = cur_word ^ s2_mask_q;
      default:  new_word = cur_word;
    endcase

    // one result slot reserved per command in flight
    room = ((RES_CNT_W + 1)'(res_cnt_i) + (RES_CNT_W + 1)'(s2_valid_q && s2_last_q)) <
           (RES_CNT_W + 1)'(RES_DEPTH);
  end

  assign cmd_pop_o             = (state_q == B_IDLE) && !cmd_empty_i && room;
  assign res_push_o            = s2_valid_q && s2_last_q;
  assign res_o.read_word       = s2_read_q ? cur_word[RD_W-1:0] : '0;
  assign res_o.range_error     = s2_err_q;
  assign clearing_o            = (state_q == B_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_CLEAR;
      clr_q      <= '0;
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s2_valid_q <= issue;
      fwd_q      <= hit;
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DEPTH - 1)) state_q <= B_IDLE;
        end
        B_IDLE: if (cmd_pop_o) state_q <= B_RUN;
        B_RUN:  if (issue_last) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q       <= cmd_i;
      row_base_q  <= cmd_i.base;
      rows_left_q <= cmd_i.rows;
      wi_q        <= cmd_i.wi0;
    end else if (issue_write) begin
      if (last_w) begin
        wi_q        <= cmd_q.wi0;
        row_base_q  <= row_base_q + BASE_W'(cmd_q.stride);
        rows_left_q <= rows_left_q - 1'b1;
      end else begin
        wi_q <= wi_q + 1'b1;
      end
    end
    s2_write_q <= issue_write;
    s2_last_q  <= issue_last;
    s2_read_q  <= cmd_q.rd;
    s2_err_q   <= cmd_q.err;
    s2_addr_q  <= issue_addr;
    s2_mask_q  <= mask;
    s2_mode_q  <= cmd_q.mode;
    if (s2_valid_q && s2_write_q) begin
      wdata_q <= new_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_CLEAR) begin
      mem_q[clr_q] <= '0;
    end else if (s2_valid_q && s2_write_q) begin
      mem_q[s2_addr_q] <= new_word;
    end
    rdata_q <= mem_q[issue_addr];
  end

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> !res_push_o)
    else $error("result issued during clearing pass");

  a_result_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(s2_valid_q && s2_write_q))
    else $error("forward without preceding write");

  a_s2_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(state_q == B_RUN))
    else $error("second stage valid without issue");

endmodule

`default_nettype wire
